FILE: hw/rtl/pfc_pkg.sv
package pfc_pkg;

   localparam int LETTER_W  = 5;
   localparam int OP_W      = 3;
   localparam int SIDE      = 5;
   localparam int CELLS     = SIDE * SIDE;
   localparam int LETTERS   = 26;
   localparam int CELL_W    = $clog2(CELLS);
   localparam int COORD_W   = $clog2(SIDE);
   localparam logic [LETTER_W-1:0] LETTER_I = LETTER_W'(8);
   localparam logic [LETTER_W-1:0] LETTER_J = LETTER_W'(9);
   localparam logic [LETTER_W-1:0] LETTER_Z = LETTER_W'(25);
   localparam logic [LETTER_W-1:0] FILLER_RESET = LETTER_Z;

   // command queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR_KEY  = 3'd0,
      OP_KEY_LETTER = 3'd1,
      OP_FINISH     = 3'd2,
      OP_ENCRYPT    = 3'd3,
      OP_DECRYPT    = 3'd4,
      OP_FLUSH      = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      CMD_CLEAR,
      CMD_PLACE,
      CMD_FINISH,
      CMD_PAIR,
      CMD_TAIL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [LETTER_W-1:0]   letter_a;
      logic [LETTER_W-1:0]   letter_b;
      logic                  decrypt;
   } cmd_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FILL,
      BK_LOOK,
      BK_FIRST,
      BK_SECOND,
      BK_TAIL
   } back_state_type;

   // saturate to z, fold j onto i
   function automatic logic [LETTER_W-1:0] norm_letter(input logic [LETTER_W-1:0] v);
      logic [LETTER_W-1:0] l;
      l = (v > LETTER_Z) ? LETTER_Z : v;
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

   function automatic logic [COORD_W-1:0] cell_row(input logic [CELL_W-1:0] c);
      logic [COORD_W-1:0] r;
      if (c >= CELL_W'(4 * SIDE))      r = COORD_W'(4);
      else if (c >= CELL_W'(3 * SIDE)) r = COORD_W'(3);
      else if (c >= CELL_W'(2 * SIDE)) r = COORD_W'(2);
      else if (c >= CELL_W'(SIDE))     r = COORD_W'(1);
      else                             r = COORD_W'(0);
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] cell_col(input logic [CELL_W-1:0] c);
      logic [CELL_W-1:0] base;
      base = CELL_W'(cell_row(c)) * CELL_W'(SIDE);
      return COORD_W'(c - base);
   endfunction

   function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] r,
                                                    input logic [COORD_W-1:0] c);
      return CELL_W'(r) * CELL_W'(SIDE) + CELL_W'(c);
   endfunction

   // one step along a row or column, wrapping; backwards when deciphering
   function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] v,
                                                    input logic dec);
      logic [COORD_W-1:0] n;
      if (dec) n = (v == '0) ? COORD_W'(SIDE - 1) : v - COORD_W'(1);
      else     n = (v == COORD_W'(SIDE - 1)) ? '0 : v + COORD_W'(1);
      return n;
   endfunction

endpackage

FILE: hw/rtl/pfc_if.sv
interface pfc_req_if;
   logic                          valid;
   logic                          ready;
   logic [pfc_pkg::OP_W-1:0]      operation;
   logic [pfc_pkg::LETTER_W-1:0]  letter;
   modport source (output valid, output operation, output letter, input ready);
   modport sink   (input valid, input operation, input letter, output ready);
endinterface

interface pfc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pfc_pkg::LETTER_W-1:0]  out_letter;
   logic                          pair_end;
   logic                          status;
   modport source (output valid, output out_letter, output pair_end, output status,
                   input ready);
   modport sink   (input valid, input out_letter, input pair_end, input status,
                   output ready);
endinterface

interface pfc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pfc_pkg::LETTER_W-1:0]  filler_letter;
   modport source (output valid, output filler_letter, input ready);
   modport sink   (input valid, input filler_letter, output ready);
endinterface

FILE: hw/rtl/pfc_front.sv
module pfc_front (
   input  logic                       clock,
   input  logic                       reset,
   pfc_req_if.sink                    req_chan,
   pfc_csr_if.sink                    csr_chan,
   input  pfc_pkg::queue_status_type  queue_status,
   output logic                       cmd_valid,
   output pfc_pkg::cmd_type           cmd
);

   logic [pfc_pkg::LETTER_W-1:0] held_letter_ff, held_letter_in;
   logic                         held_valid_ff, held_valid_in;
   logic                         held_decrypt_ff, held_decrypt_in;
   logic [pfc_pkg::LETTER_W-1:0] filler_ff;
   logic [pfc_pkg::LETTER_W-1:0] letter_n;
   logic [pfc_pkg::LETTER_W-1:0] fill_n;
   logic                         accept;

   assign req_chan.ready = !queue_status.full;
   assign csr_chan.ready = 1'b1;
   assign accept   = req_chan.valid && req_chan.ready;
   assign letter_n = pfc_pkg::norm_letter(req_chan.letter);
   assign fill_n   = pfc_pkg::norm_letter(filler_ff);

   always_comb begin
      held_letter_in  = held_letter_ff;
      held_valid_in   = held_valid_ff;
      held_decrypt_in = held_decrypt_ff;
      cmd_valid       = 1'b0;
      cmd.kind        = pfc_pkg::CMD_PAIR;
      cmd.letter_a    = held_letter_ff;
      cmd.letter_b    = letter_n;
      cmd.decrypt     = 1'b0;
      if (accept) begin
         case (pfc_pkg::op_type'(req_chan.operation))
            pfc_pkg::OP_CLEAR_KEY: begin
               cmd_valid       = 1'b1;
               cmd.kind        = pfc_pkg::CMD_CLEAR;
               held_letter_in  = '0;
               held_valid_in   = 1'b0;
               held_decrypt_in = 1'b0;
            end
            pfc_pkg::OP_KEY_LETTER: begin
               cmd_valid    = 1'b1;
               cmd.kind     = pfc_pkg::CMD_PLACE;
               cmd.letter_a = letter_n;
            end
            pfc_pkg::OP_FINISH: begin
               cmd_valid = 1'b1;
               cmd.kind  = pfc_pkg::CMD_FINISH;
            end
            pfc_pkg::OP_ENCRYPT: begin
               if (held_valid_ff && !held_decrypt_ff) begin
                  cmd_valid = 1'b1;
                  // doubled letter: pair with filler and keep holding it
                  if (held_letter_ff == letter_n) cmd.letter_b = fill_n;
                  else held_valid_in = 1'b0;
               end else begin
                  held_letter_in  = letter_n;
                  held_valid_in   = 1'b1;
                  held_decrypt_in = 1'b0;
               end
            end
            pfc_pkg::OP_DECRYPT: begin
               if (held_valid_ff && held_decrypt_ff) begin
                  cmd_valid       = 1'b1;
                  cmd.decrypt     = 1'b1;
                  held_valid_in   = 1'b0;
                  held_decrypt_in = 1'b0;
               end else begin
                  held_letter_in  = letter_n;
                  held_valid_in   = 1'b1;
                  held_decrypt_in = 1'b1;
               end
            end
            pfc_pkg::OP_FLUSH: begin
               if (held_valid_ff) begin
                  cmd_valid       = 1'b1;
                  held_valid_in   = 1'b0;
                  held_decrypt_in = 1'b0;
                  if (held_decrypt_ff) cmd.kind = pfc_pkg::CMD_TAIL;
                  else cmd.letter_b = fill_n;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_letter_ff  <= '0;
         held_valid_ff   <= 1'b0;
         held_decrypt_ff <= 1'b0;
         filler_ff       <= pfc_pkg::FILLER_RESET;
      end else begin
         held_letter_ff  <= held_letter_in;
         held_valid_ff   <= held_valid_in;
         held_decrypt_ff <= held_decrypt_in;
         if (csr_chan.valid && csr_chan.ready) filler_ff <= csr_chan.filler_letter;
      end
   end

endmodule

FILE: hw/rtl/pfc_cmd_fifo.sv
module pfc_cmd_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pfc_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output pfc_pkg::cmd_type           head_cmd,
   output pfc_pkg::queue_status_type  queue_status
);

   pfc_pkg::cmd_type                slot_ff [pfc_pkg::QUEUE_DEPTH];
   logic [pfc_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pfc_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pfc_pkg::QCOUNT_W-1:0]    count_ff, count_in;

   assign head_cmd           = slot_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == pfc_pkg::QCOUNT_W'(pfc_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign queue_status.count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pfc_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + pfc_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + pfc_pkg::QCOUNT_W'(1);
      else if (pop && !push) count_in = count_ff - pfc_pkg::QCOUNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

FILE: hw/rtl/pfc_back.sv
module pfc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pfc_pkg::cmd_type           head_cmd,
   input  pfc_pkg::queue_status_type  queue_status,
   output logic                       pop,
   pfc_rsp_if.source                  rsp_chan
);

   pfc_pkg::back_state_type          state_ff, state_in;
   logic [pfc_pkg::LETTERS-1:0]      present_ff, present_in;
   logic [pfc_pkg::CELL_W-1:0]       fill_ff, fill_in;
   logic [pfc_pkg::LETTER_W-1:0]     walk_ff, walk_in;

   logic [pfc_pkg::LETTER_W-1:0]     square_mem   [pfc_pkg::CELLS];
   logic [pfc_pkg::CELL_W-1:0]       position_mem [pfc_pkg::LETTERS];

   pfc_pkg::cmd_type                 cmd_ff;
   logic [pfc_pkg::CELL_W-1:0]       pos_a_ff, pos_b_ff;
   logic [pfc_pkg::LETTER_W-1:0]     sq_a_ff, sq_b_ff;

   logic                             placing;
   logic [pfc_pkg::LETTER_W-1:0]     place_letter;
   logic                             place_en;

   logic [pfc_pkg::COORD_W-1:0]      r1, c1, r2, c2;
   logic [pfc_pkg::COORD_W-1:0]      r1n, c1n, r2n, c2n;
   logic [pfc_pkg::CELL_W-1:0]       cell_a, cell_b;

   assign pop = (state_ff == pfc_pkg::BK_IDLE) && !queue_status.empty;

   assign place_en = placing && (fill_ff < pfc_pkg::CELL_W'(pfc_pkg::CELLS))
                     && !present_ff[place_letter];

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      fill_in      = fill_ff;
      walk_in      = walk_ff;
      placing      = 1'b0;
      place_letter = head_cmd.letter_a;
      case (state_ff)
         pfc_pkg::BK_IDLE: begin
            if (pop) begin
               case (head_cmd.kind)
                  pfc_pkg::CMD_CLEAR: begin
                     present_in = '0;
                     fill_in    = '0;
                  end
                  pfc_pkg::CMD_PLACE:  placing = 1'b1;
                  pfc_pkg::CMD_FINISH: begin
                     walk_in  = '0;
                     state_in = pfc_pkg::BK_FILL;
                  end
                  pfc_pkg::CMD_PAIR: state_in = pfc_pkg::BK_LOOK;
                  pfc_pkg::CMD_TAIL: state_in = pfc_pkg::BK_TAIL;
                  default: begin
                  end
               endcase
            end
         end
         pfc_pkg::BK_FILL: begin
            place_letter = walk_ff;
            placing      = (walk_ff != pfc_pkg::LETTER_J);
            walk_in      = walk_ff + pfc_pkg::LETTER_W'(1);
            if (walk_ff == pfc_pkg::LETTER_W'(pfc_pkg::LETTERS - 1))
               state_in = pfc_pkg::BK_IDLE;
         end
         pfc_pkg::BK_LOOK:   state_in = pfc_pkg::BK_FIRST;
         pfc_pkg::BK_FIRST:  if (rsp_chan.ready) state_in = pfc_pkg::BK_SECOND;
         pfc_pkg::BK_SECOND: if (rsp_chan.ready) state_in = pfc_pkg::BK_IDLE;
         pfc_pkg::BK_TAIL:   if (rsp_chan.ready) state_in = pfc_pkg::BK_IDLE;
         default: state_in = pfc_pkg::BK_IDLE;
      endcase
      if (place_en) begin
         present_in[place_letter] = 1'b1;
         fill_in = fill_ff + pfc_pkg::CELL_W'(1);
      end
   end

   // digraph rules on the two looked-up cells
   always_comb begin
      r1  = pfc_pkg::cell_row(pos_a_ff);
      c1  = pfc_pkg::cell_col(pos_a_ff);
      r2  = pfc_pkg::cell_row(pos_b_ff);
      c2  = pfc_pkg::cell_col(pos_b_ff);
      r1n = r1;
      c1n = c1;
      r2n = r2;
      c2n = c2;
      if (r1 == r2 && c1 != c2) begin
         c1n = pfc_pkg::wrap_step(c1, cmd_ff.decrypt);
         c2n = pfc_pkg::wrap_step(c2, cmd_ff.decrypt);
      end else if (c1 == c2 && r1 != r2) begin
         r1n = pfc_pkg::wrap_step(r1, cmd_ff.decrypt);
         r2n = pfc_pkg::wrap_step(r2, cmd_ff.decrypt);
      end else if (r1 != r2 && c1 != c2) begin
         c1n = c2;
         c2n = c1;
      end
      cell_a = pfc_pkg::cell_index(r1n, c1n);
      cell_b = pfc_pkg::cell_index(r2n, c2n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pfc_pkg::BK_IDLE;
         present_ff <= '0;
         fill_ff    <= '0;
         walk_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         fill_ff    <= fill_in;
         walk_ff    <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (place_en) begin
         square_mem[fill_ff]        <= place_letter;
         position_mem[place_letter] <= fill_ff;
      end
      if (pop) begin
         cmd_ff   <= head_cmd;
         pos_a_ff <= position_mem[head_cmd.letter_a];
         pos_b_ff <= position_mem[head_cmd.letter_b];
      end
      if (state_ff == pfc_pkg::BK_LOOK) begin
         sq_a_ff <= square_mem[cell_a];
         sq_b_ff <= square_mem[cell_b];
      end
   end

   assign rsp_chan.valid      = (state_ff == pfc_pkg::BK_FIRST)
                             || (state_ff == pfc_pkg::BK_SECOND)
                             || (state_ff == pfc_pkg::BK_TAIL);
   assign rsp_chan.out_letter = (state_ff == pfc_pkg::BK_FIRST)  ? sq_a_ff :
                                (state_ff == pfc_pkg::BK_SECOND) ? sq_b_ff : '0;
   assign rsp_chan.pair_end   = (state_ff == pfc_pkg::BK_SECOND);
   assign rsp_chan.status     = (state_ff == pfc_pkg::BK_TAIL);

endmodule

FILE: hw/rtl/playfair_digraph_cipher.sv
// Flow: a word is taken every cycle while the command queue has room; a completed pair passes
//   the queue, position lookup and square read before its first output word, and the second
//   follows once the first is taken. The back end takes a key letter or clear while idle, and
//   walks the alphabet to finish the square, taking no new command until it is back in idle.
// Reset: synchronous; clears the held letter, placed-letter flags, fill count, queue and filler
//   (z). The key square and position memories are not cleared and hold nothing until written.
module playfair_digraph_cipher (
   input  logic        clock,
   input  logic        reset,
   pfc_req_if.sink     req_chan,
   pfc_rsp_if.source   rsp_chan,
   pfc_csr_if.sink     csr_chan
);

   // front: take words, keep the held letter, turn each word into at most one command
   // queue: lets the front keep taking words while the back end is busy or stalled
   // back: owns the key square, runs the digraph rules and drives the output word

   logic                       cmd_valid;
   pfc_pkg::cmd_type           cmd;
   pfc_pkg::cmd_type           head_cmd;
   pfc_pkg::queue_status_type  queue_status;
   logic                       pop;

   pfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_chan     (csr_chan),
      .queue_status (queue_status),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd)
   );

   pfc_cmd_fifo u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (cmd_valid),
      .push_cmd     (cmd),
      .pop          (pop),
      .head_cmd     (head_cmd),
      .queue_status (queue_status)
   );

   pfc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

   // the second letter of a pair follows its first word straight away
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.pair_end && !rsp_chan.status
      |=> rsp_chan.valid && rsp_chan.pair_end)
      else $error("pair first word not followed by its second");

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> !queue_status.full)
      else $error("command pushed into full queue");

   // fill level tracks a lone push
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && !pop |=> queue_status.count == $past(queue_status.count) + 1'b1)
      else $error("queue count did not advance on push");

   // the back end only pops a waiting command
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty && !rsp_chan.valid)
      else $error("pop from empty queue or while output busy");

endmodule
